[rtl/tpfa_pkg.sv]
`default_nettype none

package tpfa_pkg;

    localparam int CMD_W       = 2;
    localparam int GRP_W       = 2;
    localparam int PIN_W       = 3;
    localparam int STAMP_W     = 64;
    localparam int FRAME_W     = 64;
    localparam int MASK_W      = 8;
    localparam int MASK_REGS   = 4;
    localparam int GROUP_COUNT = 4;
    localparam int CFG_ADDR_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_TRIGGER   = 2'd0,
        CMD_POP       = 2'd1,
        CMD_CLEAR_PIN = 2'd2,
        CMD_CLEAR_ALL = 2'd3
    } t_cmd;

    // us to ns: x * 1000 = x * 1024 - x * 16 - x * 8, wrapping at 64 bits
    function automatic logic [STAMP_W-1:0] f_us_to_ns(input logic [STAMP_W-1:0] us);
        return (us << 10) - (us << 4) - (us << 3);
    endfunction

endpackage

`default_nettype wire

[rtl/tpfa_ring_bank.sv]
`default_nettype none

module tpfa_ring_bank #(
    parameter int DEPTH = 256,
    localparam int PTR_W = $clog2(DEPTH)
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_we,
    input  wire logic [PTR_W-1:0]                i_waddr,
    input  wire logic [tpfa_pkg::STAMP_W-1:0]    i_wdata,
    input  wire logic                            i_re,
    input  wire logic [PTR_W-1:0]                i_raddr,
    output logic      [tpfa_pkg::STAMP_W-1:0]    o_rdata
);
    import tpfa_pkg::*;

    logic [STAMP_W-1:0] r_mem [DEPTH];
    logic [STAMP_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // hold the last read word until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/tpfa_ctrl.sv]
`default_nettype none

module tpfa_ctrl #(
    parameter int LANES      = 8,
    parameter int RING_DEPTH = 256,
    localparam int PTR_W = $clog2(RING_DEPTH),
    localparam int CNT_W = $clog2(RING_DEPTH + 1)
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_fire,
    input  wire tpfa_pkg::t_cmd                 i_cmd,
    input  wire logic [tpfa_pkg::MASK_W-1:0]    i_push_mask,
    input  wire logic [tpfa_pkg::PIN_W-1:0]     i_pin,
    input  wire logic [tpfa_pkg::FRAME_W-1:0]   i_frame,
    output logic      [LANES-1:0]               o_we,
    output logic      [PTR_W-1:0]               o_waddr [LANES],
    output logic      [LANES-1:0]               o_re,
    output logic      [PTR_W-1:0]               o_raddr,
    output logic                                o_found
);
    import tpfa_pkg::*;

    localparam int SUM_W = PTR_W + 1;

    logic [LANES-1:0]   sel;
    logic [PTR_W-1:0]   lane_head  [LANES];
    logic [CNT_W-1:0]   lane_count [LANES];
    logic [FRAME_W-1:0] lane_last  [LANES];
    logic [LANES-1:0]   lane_seen;

    logic [PTR_W-1:0]   s_head;
    logic [CNT_W-1:0]   s_count;
    logic [FRAME_W-1:0] s_last;
    logic               s_seen;
    logic [FRAME_W-1:0] gap;
    logic [CNT_W-1:0]   take;
    logic [SUM_W-1:0]   pos_sum;
    logic [PTR_W-1:0]   pos;
    logic [PTR_W-1:0]   pos_next;
    logic               found;
    logic               pop_go;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            sel[l] = (i_pin == PIN_W'(l));
        end
    end

    // pick the addressed pin; a pin without a lane reads as an empty ring
    always_comb begin
        s_head  = '0;
        s_count = '0;
        s_last  = '0;
        s_seen  = 1'b0;
        for (int l = 0; l < LANES; l++) begin
            if (sel[l]) begin
                s_head  = lane_head[l];
                s_count = lane_count[l];
                s_last  = lane_last[l];
                s_seen  = lane_seen[l];
            end
        end
    end

    always_comb begin
        gap     = s_seen ? (i_frame - s_last) : FRAME_W'(1);
        take    = (gap > FRAME_W'(s_count)) ? s_count : gap[CNT_W-1:0];
        pos_sum = SUM_W'(s_head) + SUM_W'(take) - SUM_W'(1);
        pos     = (pos_sum >= SUM_W'(RING_DEPTH)) ? PTR_W'(pos_sum - SUM_W'(RING_DEPTH))
                                                  : PTR_W'(pos_sum);
        pos_next = (pos == PTR_W'(RING_DEPTH - 1)) ? '0 : pos + PTR_W'(1);
        found   = (i_cmd == CMD_POP) && (s_count != '0) && !(s_seen && (i_frame <= s_last));
        pop_go  = i_fire && found;
    end

    assign o_raddr = pos;
    assign o_found = found;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic               push;
        logic               clr;
        logic               full;
        logic [SUM_W-1:0]   slot_sum;
        logic [PTR_W-1:0]   slot;
        logic [PTR_W-1:0]   head_inc;
        logic [PTR_W-1:0]   r_head;
        logic [PTR_W-1:0]   n_head;
        logic [CNT_W-1:0]   r_count;
        logic [CNT_W-1:0]   n_count;
        logic [FRAME_W-1:0] r_last;
        logic [FRAME_W-1:0] n_last;
        logic               r_seen;
        logic               n_seen;

        assign push = i_fire && (i_cmd == CMD_TRIGGER) && i_push_mask[l];
        assign clr  = i_fire && ((i_cmd == CMD_CLEAR_ALL) ||
                                 ((i_cmd == CMD_CLEAR_PIN) && sel[l]));
        assign full = (r_count == CNT_W'(RING_DEPTH));

        // on a full ring head+count wraps back onto head: overwrite oldest
        assign slot_sum = SUM_W'(r_head) + SUM_W'(r_count);
        assign slot     = (slot_sum >= SUM_W'(RING_DEPTH))
                          ? PTR_W'(slot_sum - SUM_W'(RING_DEPTH)) : PTR_W'(slot_sum);
        assign head_inc = (r_head == PTR_W'(RING_DEPTH - 1)) ? '0 : r_head + PTR_W'(1);

        always_comb begin
            n_head  = r_head;
            n_count = r_count;
            n_last  = r_last;
            n_seen  = r_seen;
            priority if (clr) begin
                n_head  = '0;
                n_count = '0;
                n_last  = '0;
                n_seen  = 1'b0;
            end else if (push) begin
                if (full) begin
                    n_head = head_inc;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end else if (pop_go && sel[l]) begin
                n_head  = pos_next;
                n_count = r_count - take;
                n_last  = i_frame;
                n_seen  = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_head  <= '0;
                r_count <= '0;
                r_last  <= '0;
                r_seen  <= 1'b0;
            end else begin
                r_head  <= n_head;
                r_count <= n_count;
                r_last  <= n_last;
                r_seen  <= n_seen;
            end
        end

        assign lane_head[l]  = r_head;
        assign lane_count[l] = r_count;
        assign lane_last[l]  = r_last;
        assign lane_seen[l]  = r_seen;
        assign o_we[l]       = push;
        assign o_waddr[l]    = slot;
        assign o_re[l]       = pop_go && sel[l];
    end

endmodule

`default_nettype wire

[rtl/trigger_pulse_frame_aligner_core.sv]
`default_nettype none

// Channel   Dir  Handshake                  Payload
// -------   ---  -------------------------  ----------------------------------------------
// s_axis    in   i_s_axis_tvalid/o_..tready  tuser: command; tdata: group, pin, stamp, frame
// m_axis    out  o_m_axis_tvalid/i_..tready  tuser: pulse_found; tdata: timestamp_ns
// cfg       in   i_cfg_we (no wait)          i_cfg_addr: mask register, i_cfg_wdata: mask
//
// A word is taken every cycle while the pipe flows. A pop word is held in the input
// register while it resolves the ring pointers and issues the ring memory read, then
// the read stamp is scaled to ns into the output register. Triggers and clears finish
// in the first stage and give no word out.
// Reset clears the masks and all ring pointers; the ring memories are not cleared
// (a ring only reads slots it has written), so no clearing pass follows reset.
// A stalled output holds its word; the two inner stages keep taking words until full.
module trigger_pulse_frame_aligner_core #(
    parameter int PIN_COUNT  = 8,
    parameter int RING_DEPTH = 256
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // [1:0] group_index, [4:2] pin, [68:5] trigger_time_us, [132:69] frame_id, [135:133] zero
    input  wire logic [135:0]                       i_s_axis_tdata,
    // [1:0] command
    input  wire logic [tpfa_pkg::CMD_W-1:0]         i_s_axis_tuser,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // [63:0] timestamp_ns
    output logic      [tpfa_pkg::STAMP_W-1:0]       o_m_axis_tdata,
    // [0] pulse_found
    output logic                                    o_m_axis_tuser,
    input  wire logic                               i_cfg_we,
    input  wire logic [tpfa_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire logic [tpfa_pkg::MASK_W-1:0]        i_cfg_wdata
);
    import tpfa_pkg::*;

    // pins beyond the mask width can never be fed, so they get no ring
    localparam int LANES = (PIN_COUNT < MASK_W) ? PIN_COUNT : MASK_W;
    localparam int PTR_W = $clog2(RING_DEPTH);

    // group masks
    logic [MASK_W-1:0] r_mask [MASK_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < MASK_REGS; g++) begin
                r_mask[g] <= '0;
            end
        end else if (i_cfg_we) begin
            r_mask[i_cfg_addr] <= i_cfg_wdata;
        end
    end

    // stage 1: input register
    logic               r1_v;
    t_cmd               r1_cmd;
    logic [GRP_W-1:0]   r1_grp;
    logic [PIN_W-1:0]   r1_pin;
    logic [STAMP_W-1:0] r1_stamp;
    logic [FRAME_W-1:0] r1_frame;

    // stage 2: ring read in flight
    logic               r2_v;
    logic               r2_found;
    logic [PIN_W-1:0]   r2_pin;

    // output register
    logic               r_out_v;
    logic               r_out_found;
    logic [STAMP_W-1:0] r_out_ns;

    logic               pop1;
    logic               out_ok;
    logic               en2;
    logic               fire1;
    logic               accept;
    logic [MASK_W-1:0]  push_mask;
    logic               found;
    logic [LANES-1:0]   we;
    logic [PTR_W-1:0]   waddr [LANES];
    logic [LANES-1:0]   re;
    logic [PTR_W-1:0]   raddr;
    logic [STAMP_W-1:0] q [LANES];
    logic [STAMP_W-1:0] rd;

    // advance a stage when the one after it is empty or moving (pops only use stage 2)
    assign pop1    = (r1_cmd == CMD_POP);
    assign out_ok  = !r_out_v || i_m_axis_tready;
    assign en2     = !r2_v || out_ok;
    assign fire1   = r1_v && (!pop1 || en2);
    assign accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = !r1_v || fire1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (o_s_axis_tready) begin
            r1_v <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_cmd   <= t_cmd'(i_s_axis_tuser);
            r1_grp   <= i_s_axis_tdata[1:0];
            r1_pin   <= i_s_axis_tdata[4:2];
            r1_stamp <= i_s_axis_tdata[68:5];
            r1_frame <= i_s_axis_tdata[132:69];
        end
    end

    // drop triggers for groups without a mask register
    assign push_mask = ({{(32-GRP_W){1'b0}}, r1_grp} < GROUP_COUNT) ? r_mask[r1_grp] : '0;

    tpfa_ctrl #(
        .LANES      (LANES),
        .RING_DEPTH (RING_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire1),
        .i_cmd       (r1_cmd),
        .i_push_mask (push_mask),
        .i_pin       (r1_pin),
        .i_frame     (r1_frame),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_re        (re),
        .o_raddr     (raddr),
        .o_found     (found)
    );

    for (genvar l = 0; l < LANES; l++) begin : g_bank
        tpfa_ring_bank #(
            .DEPTH (RING_DEPTH)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (we[l]),
            .i_waddr (waddr[l]),
            .i_wdata (r1_stamp),
            .i_re    (re[l]),
            .i_raddr (raddr),
            .o_rdata (q[l])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en2) begin
            r2_v <= fire1 && pop1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && fire1 && pop1) begin
            r2_found <= found;
            r2_pin   <= r1_pin;
        end
    end

    // select the bank that took the read
    always_comb begin
        rd = '0;
        for (int l = 0; l < LANES; l++) begin
            if (r2_pin == PIN_W'(l)) begin
                rd = q[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_ok) begin
            r_out_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ok && r2_v) begin
            r_out_found <= r2_found;
            r_out_ns    <= r2_found ? f_us_to_ns(rd) : '0;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_ns;
    assign o_m_axis_tuser  = r_out_found;

endmodule

`default_nettype wire

[tb/pulse_pop_checker.sv]
`default_nettype none

module pulse_pop_checker
    import tpfa_pkg::*;
#(
    parameter int PINS  = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    input  wire logic                  i_s_tready,
    // [1:0] group_index, [4:2] pin, [68:5] trigger_time_us, [132:69] frame_id, [135:133] zero
    input  wire logic [135:0]          i_s_tdata,
    // [1:0] command
    input  wire logic [CMD_W-1:0]      i_s_tuser,
    input  wire logic                  i_m_tvalid,
    input  wire logic                  i_m_tready,
    // [63:0] timestamp_ns
    input  wire logic [STAMP_W-1:0]    i_m_tdata,
    // [0] pulse_found
    input  wire logic                  i_m_tuser,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [MASK_W-1:0]     i_cfg_wdata,
    output int                         o_fail_count,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDX_W = $clog2(DEPTH);

    typedef struct packed {
        logic               found;
        logic [STAMP_W-1:0] ns;
    } pulse_result_t;

    pulse_result_t      pop_results_q [$];
    logic [STAMP_W-1:0] ring_mem   [PINS][DEPTH];
    logic [IDX_W-1:0]   oldest_idx [PINS];
    logic [IDX_W:0]     held_cnt   [PINS];
    logic [FRAME_W-1:0] prev_frame [PINS];
    logic               prev_valid [PINS];
    logic [MASK_W-1:0]  grp_mask   [MASK_REGS];

    int fail_cnt    = 0;
    int pending_cnt = 0;

    assign o_fail_count = fail_cnt;
    assign o_pending    = pending_cnt;

    task automatic clear_ring(input int unsigned p);
        oldest_idx[p] = '0;
        held_cnt[p]   = '0;
        prev_frame[p] = '0;
        prev_valid[p] = 1'b0;
    endtask

    // Full ring: overwrite the oldest slot and advance past it.
    task automatic push_pulse(input int unsigned p, input logic [STAMP_W-1:0] us);
        int unsigned slot;
        if (held_cnt[p] >= DEPTH) begin
            ring_mem[p][oldest_idx[p]] = us;
            oldest_idx[p] = IDX_W'((oldest_idx[p] + 1) % DEPTH);
        end else begin
            slot = (oldest_idx[p] + held_cnt[p]) % DEPTH;
            ring_mem[p][slot] = us;
            held_cnt[p] = held_cnt[p] + 1'b1;
        end
    endtask

    // Skip gap-1 pulses and take the next; clamp the gap to what the ring holds.
    task automatic take_pulse(input int unsigned p, input logic [FRAME_W-1:0] frame,
                              output pulse_result_t res);
        logic [FRAME_W-1:0] gap;
        int unsigned        take;
        int unsigned        pos;
        res = '0;
        if (held_cnt[p] == 0)
            return;
        gap = 64'd1;
        if (prev_valid[p]) begin
            if (frame <= prev_frame[p])
                return;
            gap = frame - prev_frame[p];
        end
        if (gap > held_cnt[p])
            take = 32'(held_cnt[p]);
        else
            take = 32'(gap);
        pos           = (oldest_idx[p] + take - 1) % DEPTH;
        res.found     = 1'b1;
        res.ns        = ring_mem[p][pos] * 64'd1000;
        oldest_idx[p] = IDX_W'((pos + 1) % DEPTH);
        held_cnt[p]   = held_cnt[p] - (IDX_W+1)'(take);
        prev_frame[p] = frame;
        prev_valid[p] = 1'b1;
    endtask

    task automatic apply_word(input t_cmd cmd, input logic [GRP_W-1:0] grp,
                              input logic [PIN_W-1:0] pin, input logic [STAMP_W-1:0] us,
                              input logic [FRAME_W-1:0] frame);
        pulse_result_t res;
        case (cmd)
            CMD_TRIGGER: begin
                if (grp < GROUP_COUNT && grp < MASK_REGS)
                    for (int p = 0; p < PINS && p < MASK_W; p++)
                        if (grp_mask[grp][p])
                            push_pulse(p, us);
            end
            CMD_POP: begin
                res = '0;
                if (pin < PINS)
                    take_pulse(32'(pin), frame, res);
                pop_results_q.insert(pop_results_q.size(), res);
            end
            CMD_CLEAR_PIN: begin
                if (pin < PINS)
                    clear_ring(32'(pin));
            end
            CMD_CLEAR_ALL: begin
                for (int p = 0; p < PINS; p++)
                    clear_ring(p);
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        pulse_result_t want;
        if (!i_rst_n) begin
            for (int p = 0; p < PINS; p++)
                clear_ring(p);
            for (int r = 0; r < MASK_REGS; r++)
                grp_mask[r] = '0;
            pop_results_q.delete();
        end else begin
            if (i_cfg_we && i_cfg_addr < MASK_REGS)
                grp_mask[i_cfg_addr] = i_cfg_wdata;
            // Compare the output first: a word taken at this edge cannot answer yet.
            if (i_m_tvalid && i_m_tready) begin
                if (pop_results_q.size() == 0) begin
                    $error("unexpected result word: pulse_found %0b timestamp_ns %h",
                           i_m_tuser, i_m_tdata);
                    fail_cnt++;
                end else begin
                    want = pop_results_q[0];
                    pop_results_q.delete(0);
                    if (i_m_tuser !== want.found) begin
                        $error("pulse_found: expected %0b, actual %0b", want.found, i_m_tuser);
                        fail_cnt++;
                    end
                    if (i_m_tdata !== want.ns) begin
                        $error("timestamp_ns: expected %h, actual %h", want.ns, i_m_tdata);
                        fail_cnt++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                apply_word(t_cmd'(i_s_tuser), i_s_tdata[1:0], i_s_tdata[4:2],
                           i_s_tdata[68:5], i_s_tdata[132:69]);
        end
        pending_cnt = pop_results_q.size();
    end

endmodule

`default_nettype wire

[tb/trigger_pulse_frame_aligner_core_tb.sv]
`default_nettype none

module trigger_pulse_frame_aligner_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tpfa_pkg::*;

    localparam int PINS  = 8;
    localparam int DEPTH = 256;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    wire                   s_tready;
    logic [135:0]          s_tdata   = '0;
    logic [CMD_W-1:0]      s_tuser   = '0;
    wire                   m_tvalid;
    logic                  m_tready  = 1'b0;
    wire  [STAMP_W-1:0]    m_tdata;
    wire                   m_tuser;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [MASK_W-1:0]     cfg_wdata = '0;

    int fails;
    int pending;

    // Stats for the closing summary
    int n_trig     = 0;
    int n_pop      = 0;
    int n_clr_pin  = 0;
    int n_clr_all  = 0;
    int n_settings = 0;

    // Set during a stretch with no idling on either side
    bit steady = 1'b0;

    int rdy_left = 0;
    int rdy_pick;

    trigger_pulse_frame_aligner_core #(
        .PIN_COUNT  (PINS),
        .RING_DEPTH (DEPTH)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    pulse_pop_checker #(
        .PINS  (PINS),
        .DEPTH (DEPTH)
    ) u_pop_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fails),
        .o_pending    (pending)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // Hard stop: far beyond the slowest legal run (long gaps, long stalls on every word).
    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: mostly ready, short stalls often, a long stall now and then.
    // Hold ready high throughout a steady stretch.
    always @(posedge clk) begin
        if (steady) begin
            m_tready <= 1'b1;
            rdy_left = 0;
        end else if (rdy_left > 0) begin
            rdy_left = rdy_left - 1;
        end else begin
            rdy_pick = $urandom_range(0, 99);
            if (rdy_pick < 60) begin
                m_tready <= 1'b1;
                rdy_left = $urandom_range(0, 7);
            end else if (rdy_pick < 92) begin
                m_tready <= 1'b0;
                rdy_left = $urandom_range(0, 2);
            end else begin
                m_tready <= 1'b0;
                rdy_left = $urandom_range(10, 40);
            end
        end
    end

    // Present one word and hold it until the handshake completes.
    // Leave tvalid high on return so back-to-back words need no second assignment.
    task automatic send_word(input t_cmd cmd, input logic [GRP_W-1:0] grp,
                             input logic [PIN_W-1:0] pin, input logic [STAMP_W-1:0] us,
                             input logic [FRAME_W-1:0] frame);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {3'b000, frame, us, pin, grp};
        do
            @(posedge clk);
        while (!s_tready);
        case (cmd)
            CMD_TRIGGER:   n_trig++;
            CMD_POP:       n_pop++;
            CMD_CLEAR_PIN: n_clr_pin++;
            CMD_CLEAR_ALL: n_clr_all++;
        endcase
    endtask

    // Idle the sender for a random stretch: mostly none, sometimes a few, rarely long.
    task automatic sender_gap();
        int pick;
        int n;
        if (steady)
            return;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            n = 0;
        else if (pick < 92)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(8, 30);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Drop tvalid, wait for every pending pop answer, then let the pipe empty
    // of triggers and clears too (two stages, plus margin).
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all four mask registers back to back; call only with the block idle.
    task automatic load_masks(input logic [MASK_W-1:0] m0, input logic [MASK_W-1:0] m1,
                              input logic [MASK_W-1:0] m2, input logic [MASK_W-1:0] m3);
        logic [MASK_W-1:0] vals [MASK_REGS];
        vals = '{m0, m1, m2, m3};
        for (int r = 0; r < MASK_REGS; r++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= CFG_ADDR_W'(r);
            cfg_wdata <= vals[r];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    initial begin
        int                 ph;
        int                 n;
        int                 items;
        int                 trig_pct;
        int                 pick;
        logic [STAMP_W-1:0] us;
        logic [FRAME_W-1:0] frame;
        logic [PIN_W-1:0]   pin;
        logic [MASK_W-1:0]  masks  [MASK_REGS];
        logic [FRAME_W-1:0] cursor [PINS];

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---------------- Directed part ----------------
        // Pop on an empty ring straight out of reset: nothing found.
        send_word(CMD_POP, 2'd0, 3'd0, 64'd0, 64'd5);
        sender_gap();
        // Trigger with every mask still zero: ignored, so the next pop finds nothing.
        send_word(CMD_TRIGGER, 2'd0, 3'd0, 64'd77, 64'd0);
        send_word(CMD_POP, 2'd0, 3'd0, 64'd0, 64'd6);
        wait_drained();

        // Group 0 feeds all pins, group 1 only pin 0, group 2 only pin 7, group 3 none.
        load_masks(8'hFF, 8'h01, 8'h80, 8'h00);
        send_word(CMD_TRIGGER, 2'd0, 3'd0, 64'd0, 64'd0);          // zero stamp
        sender_gap();
        send_word(CMD_TRIGGER, 2'd1, 3'd7, '1, '1);                // max stamp, wraps at x1000
        send_word(CMD_TRIGGER, 2'd2, 3'd5, {$urandom, $urandom}, 64'd0);
        sender_gap();
        send_word(CMD_TRIGGER, 2'd3, 3'd2, 64'd5, 64'd0);          // empty mask: ignored
        // First pop takes the oldest pulse, whatever the frame id.
        send_word(CMD_POP, 2'd3, 3'd0, 64'd0, 64'd10);
        // Duplicate id, then an older id: nothing found, ring untouched.
        send_word(CMD_POP, 2'd0, 3'd0, 64'd0, 64'd10);
        sender_gap();
        send_word(CMD_POP, 2'd0, 3'd0, 64'd0, 64'd9);
        // Gap beyond what the ring holds: take the newest.
        send_word(CMD_POP, 2'd1, 3'd0, '1, 64'd12);
        send_word(CMD_POP, 2'd2, 3'd0, 64'd0, 64'd13);             // ring now empty
        sender_gap();
        // Largest frame id on a fresh pin, then id zero counts as older.
        send_word(CMD_POP, 2'd0, 3'd7, 64'd0, '1);
        send_word(CMD_POP, 2'd0, 3'd7, 64'd0, 64'd0);
        // Clear one pin: the next pop sees an empty ring.
        send_word(CMD_CLEAR_PIN, 2'd3, 3'd7, '1, '1);
        send_word(CMD_POP, 2'd0, 3'd7, 64'd0, 64'd0);
        sender_gap();
        send_word(CMD_TRIGGER, 2'd0, 3'd0, 64'd1, 64'd0);
        send_word(CMD_TRIGGER, 2'd0, 3'd0, 64'd2, 64'd0);
        send_word(CMD_TRIGGER, 2'd0, 3'd0, 64'd3, 64'd0);
        send_word(CMD_POP, 2'd0, 3'd3, 64'd0, 64'd0);
        send_word(CMD_POP, 2'd0, 3'd3, 64'd0, 64'd2);
        // Clear everything: pins 3 and 5 then answer empty.
        send_word(CMD_CLEAR_ALL, 2'd0, 3'd0, 64'd0, 64'd0);
        send_word(CMD_POP, 2'd0, 3'd3, 64'd0, 64'd3);
        send_word(CMD_POP, 2'd0, 3'd5, 64'd0, 64'd1);

        // ---------------- Random part ----------------
        // Start each pin's frame counter anywhere in the 64-bit space.
        for (int p = 0; p < PINS; p++)
            cursor[p] = {$urandom, $urandom};

        for (ph = 0; ph < 8; ph++) begin
            wait_drained();
            steady = 1'b0;
            for (int r = 0; r < MASK_REGS; r++)
                masks[r] = ($urandom_range(0, 4) == 0) ? 8'h00 : MASK_W'($urandom);
            case (ph)
                0:       load_masks(8'hFF, 8'hFF, 8'hFF, 8'hFF);
                // Trigger-heavy phase: triggers from groups 0 to 2 feed every pin, so rings overflow.
                1:       load_masks(8'hFF, 8'hFF, 8'hFF, masks[3]);
                2:       load_masks(8'h00, 8'h00, 8'h00, 8'h00);
                default: load_masks(masks[0], masks[1], masks[2], masks[3]);
            endcase
            steady   = (ph == 3);
            items    = (ph == 1) ? 320 : (ph == 2) ? 40 : 75;
            trig_pct = (ph == 1) ? 90 : 45;

            for (n = 0; n < items; n++) begin
                pin = PIN_W'($urandom);
                case ($urandom_range(0, 19))
                    0:       us = '0;
                    1, 2:    us = ~64'($urandom_range(0, 999));
                    3, 4, 5: us = 64'($urandom_range(0, 100000));
                    default: us = {$urandom, $urandom};
                endcase
                pick = $urandom_range(0, 99);
                if (pick < trig_pct) begin
                    send_word(CMD_TRIGGER, GRP_W'($urandom), pin, us, {$urandom, $urandom});
                end else if (pick < 95 || ph == 1) begin
                    // Mostly in-order frames; some skips, repeats, steps back and wild ids.
                    pick = $urandom_range(0, 19);
                    if (pick < 14)
                        frame = cursor[pin] + 64'd1;
                    else if (pick < 17)
                        frame = cursor[pin] + 64'($urandom_range(2, 6));
                    else if (pick == 17)
                        frame = cursor[pin];
                    else if (pick == 18)
                        frame = cursor[pin] - 64'($urandom_range(1, 3));
                    else
                        frame = {$urandom, $urandom};
                    if (pick != 18)
                        cursor[pin] = frame;
                    send_word(CMD_POP, GRP_W'($urandom), pin, us, frame);
                end else if (pick < 99) begin
                    send_word(CMD_CLEAR_PIN, GRP_W'($urandom), pin, us, {$urandom, $urandom});
                end else begin
                    send_word(CMD_CLEAR_ALL, GRP_W'($urandom), pin, us, {$urandom, $urandom});
                end
                sender_gap();
                // Now and then hold off until every answer is back.
                if ($urandom_range(0, 99) < 2)
                    wait_drained();
            end
        end
        steady = 1'b0;

        wait_drained();
        repeat (8) @(posedge clk);

        $display("Covered %0d triggers, %0d pops, %0d pin clears, %0d full clears",
                 n_trig, n_pop, n_clr_pin, n_clr_all);
        $display("over %0d mask settings, incl. ring overflow, frame skips and output stalls",
                 n_settings);
        if (fails == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
